@@ sv/quaternion_rotate_vector_unit_defines.svh @@
// Assertion macros for the quaternion rotate vector unit.
// Included by RTL files that carry concurrent assertions; no dependencies.
`ifndef QUATERNION_ROTATE_VECTOR_UNIT_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QRV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QRV_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define QRV_ASSERT(lbl, clk, rstn, prop, msg)
`define QRV_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

@@ sv/qrv_pkg.sv @@
// Package for the quaternion rotate vector unit: payload structs and constants.
// No dependencies.
package qrv_pkg;

  localparam int unsigned QuoW = 17;
  localparam int unsigned RemW = 52;
  localparam int unsigned DenW = 34;
  localparam logic signed [15:0] SatMax = 16'sh7fff;
  localparam logic signed [15:0] SatMin = -16'sh8000;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               zero_quat;
  } out_t;

  typedef struct packed {
    logic neg;
    logic sat;
    logic zero;
  } ctl_t;

endpackage

@@ sv/quaternion_rotate_vector_unit.sv @@
// Quaternion rotate vector unit: pipelined DCM rotation with restoring division.
// Depends on qrv_pkg and quaternion_rotate_vector_unit_defines.svh.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries a quaternion (w,x,y,z) and a
//   vector, signed Q1.14. Output channel out_valid_o / out_stall_i carries the
//   rotated vector, saturated to 16 bits, and the zero_quat flag (set, with a
//   zero vector, when all quaternion components are zero).
//   The result reaches out_valid_o through 23 register stages: four stages of
//   products and sums, one setup stage, 17 restoring division stages (one
//   quotient bit each against twice the squared norm) and the output register.
//   Throughput is one transaction per cycle while the pipeline is not frozen
//   by out_stall_i; every stage holds its own valid.
//   Reset clears all valid bits; the pipeline comes up empty.
//   When out_stall_i holds a valid result, the whole pipeline freezes and
//   in_stall_o rises; nothing is lost or repeated.
`include "quaternion_rotate_vector_unit_defines.svh"

module quaternion_rotate_vector_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qrv_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qrv_pkg::out_t  out_o
);

  localparam int unsigned NSteps = qrv_pkg::QuoW;

  logic en;
  logic out_valid_q;
  qrv_pkg::out_t out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // stage 1: products
  logic v1_q;
  logic signed [31:0] w2_q, x2_q, y2_q, z2_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic signed [15:0] vx1_q, vy1_q, vz1_q;

  // stage 2: matrix and norm
  logic v2_q;
  logic signed [33:0] m_q [0:8];
  logic [32:0] n2_q;
  logic signed [15:0] vx2_q, vy2_q, vz2_q;

  // stage 3: matrix-vector products
  logic v3_q;
  logic signed [49:0] mv_q [0:8];
  logic [32:0] n3_q;

  // stage 4: numerators
  logic v4_q;
  logic signed [50:0] num_q [0:2];
  logic [32:0] n4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q  <= in_i.quat_w * in_i.quat_w;
      x2_q  <= in_i.quat_x * in_i.quat_x;
      y2_q  <= in_i.quat_y * in_i.quat_y;
      z2_q  <= in_i.quat_z * in_i.quat_z;
      xy_q  <= in_i.quat_x * in_i.quat_y;
      wz_q  <= in_i.quat_w * in_i.quat_z;
      xz_q  <= in_i.quat_x * in_i.quat_z;
      wy_q  <= in_i.quat_w * in_i.quat_y;
      yz_q  <= in_i.quat_y * in_i.quat_z;
      wx_q  <= in_i.quat_w * in_i.quat_x;
      vx1_q <= in_i.vec_x;
      vy1_q <= in_i.vec_y;
      vz1_q <= in_i.vec_z;

      m_q[0] <= 34'(w2_q) + 34'(x2_q) - 34'(y2_q) - 34'(z2_q);
      m_q[1] <= (34'(xy_q) + 34'(wz_q)) <<< 1;
      m_q[2] <= (34'(xz_q) - 34'(wy_q)) <<< 1;
      m_q[3] <= (34'(xy_q) - 34'(wz_q)) <<< 1;
      m_q[4] <= 34'(w2_q) - 34'(x2_q) + 34'(y2_q) - 34'(z2_q);
      m_q[5] <= (34'(yz_q) + 34'(wx_q)) <<< 1;
      m_q[6] <= (34'(xz_q) + 34'(wy_q)) <<< 1;
      m_q[7] <= (34'(yz_q) - 34'(wx_q)) <<< 1;
      m_q[8] <= 34'(w2_q) - 34'(x2_q) - 34'(y2_q) + 34'(z2_q);
      n2_q   <= 33'(w2_q[30:0]) + 33'(x2_q[30:0]) + 33'(y2_q[30:0]) + 33'(z2_q[30:0]);
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      vz2_q  <= vz1_q;

      for (int r = 0; r < 3; r++) begin
        mv_q[3*r]   <= m_q[3*r]   * vx2_q;
        mv_q[3*r+1] <= m_q[3*r+1] * vy2_q;
        mv_q[3*r+2] <= m_q[3*r+2] * vz2_q;
      end
      n3_q <= n2_q;

      for (int r = 0; r < 3; r++) begin
        num_q[r] <= 51'(mv_q[3*r]) + 51'(mv_q[3*r+1]) + 51'(mv_q[3*r+2]);
      end
      n4_q <= n3_q;
    end
  end

  // stage 5 and division stages: index 0 is setup, 1..NSteps are quotient bits
  logic                              dv_q  [0:NSteps];
  qrv_pkg::ctl_t [2:0]               ctl_q [0:NSteps];
  logic [2:0][qrv_pkg::RemW-1:0]     rem_q [0:NSteps];
  logic [2:0][qrv_pkg::QuoW-1:0]     quo_q [0:NSteps];
  logic [qrv_pkg::DenW-1:0]          den_q [0:NSteps];

  logic [2:0][50:0]               mag_d;
  logic [2:0][qrv_pkg::RemW-1:0]  a_d;
  logic [qrv_pkg::DenW-1:0]       d_d;

  always_comb begin
    d_d = {n4_q, 1'b0};
    for (int r = 0; r < 3; r++) begin
      mag_d[r] = num_q[r][50] ? 51'(-num_q[r]) : 51'(num_q[r]);
      a_d[r]   = {mag_d[r], 1'b0} + qrv_pkg::RemW'(n4_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0] <= d_d;
      for (int r = 0; r < 3; r++) begin
        rem_q[0][r]    <= a_d[r];
        quo_q[0][r]    <= '0;
        ctl_q[0][r].neg  <= num_q[r][50];
        ctl_q[0][r].sat  <= a_d[r] >= (qrv_pkg::RemW'(d_d) << NSteps);
        ctl_q[0][r].zero <= (n4_q == '0);
      end
    end
  end

  for (genvar j = 0; j < NSteps; j++) begin : g_div
    localparam int unsigned Sh = NSteps - 1 - j;
    logic [qrv_pkg::RemW-1:0] dsh;
    logic [2:0]               ge;

    always_comb begin
      dsh = qrv_pkg::RemW'(den_q[j]) << Sh;
      for (int r = 0; r < 3; r++) begin
        ge[r] = rem_q[j][r] >= dsh;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[j+1] <= den_q[j];
        ctl_q[j+1] <= ctl_q[j];
        for (int r = 0; r < 3; r++) begin
          rem_q[j+1][r] <= ge[r] ? rem_q[j][r] - dsh : rem_q[j][r];
          quo_q[j+1][r] <= {quo_q[j][r][qrv_pkg::QuoW-2:0], ge[r]};
        end
      end
    end
  end

  // output: clamp, sign, zero forcing
  logic [2:0][15:0] res_d;

  always_comb begin
    logic [qrv_pkg::QuoW-1:0] q;
    for (int r = 0; r < 3; r++) begin
      q = ctl_q[NSteps][r].sat ? '1 : quo_q[NSteps][r];
      if (ctl_q[NSteps][r].zero) begin
        res_d[r] = '0;
      end else if (ctl_q[NSteps][r].neg) begin
        res_d[r] = (q > 17'd32768) ? qrv_pkg::SatMin : 16'(-q);
      end else begin
        res_d[r] = (q > 17'd32767) ? qrv_pkg::SatMax : q[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[NSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.rot_x     <= res_d[0];
      out_q.rot_y     <= res_d[1];
      out_q.rot_z     <= res_d[2];
      out_q.zero_quat <= ctl_q[NSteps][0].zero;
    end
  end

  `QRV_ASSERT(a_zero_out, clk_i, rst_ni, out_valid_o && out_o.zero_quat |-> out_o.rot_x == '0 && out_o.rot_y == '0 && out_o.rot_z == '0, "zero quaternion with nonzero result")
  `QRV_ASSERT(a_stall_src, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "stall without held result")
  `QRV_ASSERT(a_enter, clk_i, rst_ni, in_valid_i && !in_stall_o |=> v1_q, "accepted transaction not in first stage")
  `QRV_ASSERT_NEVER(a_neg_sat, clk_i, rst_ni, out_valid_o && !out_o.zero_quat && out_o.rot_x == 16'sh7fff && $past(en) && $past(ctl_q[NSteps][0].neg) && $past(dv_q[NSteps]), "negative result saturated positive")

endmodule

@@ bench/quaternion_rotate_vector_unit_tb.sv @@
// Testbench for quaternion_rotate_vector_unit: directed and random transactions with
// random idling on both channels, checked against a built-in rotation predictor.
// Depends on qrv_pkg and the unit RTL.
module quaternion_rotate_vector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  qrv_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qrv_pkg::out_t out_o;

  qrv_pkg::in_t pending_q[$];
  qrv_pkg::out_t rotated_q[$];
  int mismatches = 0;
  bit quiet = 0;
  int hold_cycles = 0;
  int gap_cycles = 0;
  int stall_cycles = 0;

  quaternion_rotate_vector_unit u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] round_div(longint num, longint den);
    longint a, q;
    bit neg;
    neg = num < 0;
    a = neg ? -num : num;
    q = (2 * a + den) / (2 * den);
    if (neg) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic qrv_pkg::out_t rotate_vector(qrv_pkg::in_t t);
    qrv_pkg::out_t r;
    longint w, x, y, z, vx, vy, vz, w2, x2, y2, z2, n;
    w = t.quat_w; x = t.quat_x; y = t.quat_y; z = t.quat_z;
    vx = t.vec_x; vy = t.vec_y; vz = t.vec_z;
    w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
    n = w2 + x2 + y2 + z2;
    r = '0;
    if (n == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    r.rot_x = round_div((w2 + x2 - y2 - z2) * vx + 2 * (x * y + w * z) * vy
                        + 2 * (x * z - w * y) * vz, n);
    r.rot_y = round_div(2 * (x * y - w * z) * vx + (w2 - x2 + y2 - z2) * vy
                        + 2 * (y * z + w * x) * vz, n);
    r.rot_z = round_div(2 * (x * z + w * y) * vx + 2 * (y * z - w * x) * vy
                        + (w2 - x2 - y2 + z2) * vz, n);
    return r;
  endfunction

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      4: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qrv_pkg::in_t random_item();
    qrv_pkg::in_t t;
    t.quat_w = pick_component();
    t.quat_x = pick_component();
    t.quat_y = pick_component();
    t.quat_z = pick_component();
    t.vec_x = pick_component();
    t.vec_y = pick_component();
    t.vec_z = pick_component();
    if ($urandom_range(0, 15) == 0) begin
      t.quat_w = '0; t.quat_x = '0; t.quat_y = '0; t.quat_z = '0;
    end
    return t;
  endfunction

  task automatic add_item(logic [15:0] w, x, y, z, vx, vy, vz);
    qrv_pkg::in_t t;
    t = {w, x, y, z, vx, vy, vz};
    pending_q.push_back(t);
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rotated_q.push_back(rotate_vector(in_i));
      void'(pending_q.pop_front());
    end
    if (in_valid_i && in_stall_o) begin
    end else if (gap_cycles > 0) begin
      gap_cycles <= gap_cycles - 1;
      in_valid_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      gap_cycles <= $urandom_range(0, 7);
      in_valid_i <= 1'b0;
    end else if (pending_q.size() > 0) begin
      in_valid_i <= 1'b1;
      in_i <= pending_q[0];
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_o);
      end else begin
        if (out_o !== rotated_q[0]) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p actual %p", rotated_q[0], out_o);
        end
        void'(rotated_q.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_cycles <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_item(0, 0, 0, 0, 16'h1234, 16'h8000, 16'h7fff);
    add_item(16'h4000, 0, 0, 0, 16'h4000, 16'hc000, 16'h2000);
    add_item(0, 16'h4000, 0, 0, 16'h4000, 16'h4000, 16'h4000);
    add_item(0, 0, 16'h4000, 0, 16'h4000, 16'h4000, 16'h4000);
    add_item(0, 0, 0, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
    add_item(16'h2d41, 0, 0, 16'h2d41, 16'h7fff, 16'h7fff, 16'h7fff);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    add_item(1, 0, 0, 0, 16'h7fff, 16'h8000, 1);
    add_item(0, 0, 0, 16'hffff, 1, 16'hffff, 0);
    add_item(16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h7fff, 16'h7fff, 16'h7fff);
    add_item(16'h2000, 16'he000, 16'h2000, 16'he000, 16'h8000, 16'h8000, 16'h8000);
    add_item(3, 1, 1, 1, 1, 0, 0);
    add_item(16'hffff, 0, 0, 16'hffff, 16'h0001, 16'h0001, 16'h0000);
    wait (pending_q.size() == 0 && rotated_q.size() == 0);
    hold_cycles = 120;
    for (k = 0; k < 200; k++) pending_q.push_back(random_item());
    wait (pending_q.size() == 0 && rotated_q.size() == 0);
    for (k = 0; k < 1100; k++) pending_q.push_back(random_item());
    wait (pending_q.size() == 0);
    quiet = 1;
    for (k = 0; k < 350; k++) pending_q.push_back(random_item());
    wait (pending_q.size() == 0);
    fork
      wait (rotated_q.size() == 0);
      repeat (20000) @(posedge clk_i);
    join_any
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
